/* hdl/imcol_pkg.sv */
// Shared types, register codes and reciprocal table for the im2col gather.
`timescale 1ns / 1ps
`default_nettype none

package imcol_pkg;

   localparam int IMAGE_WORDS_DEFAULT = 4096;
   // Wide enough for any store index the address math can produce.
   localparam int IDX_W = 28;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [2:0] CSR_INPUT_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_INPUT_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_KERNEL_SIZE   = 3'd2;
   localparam logic [2:0] CSR_STRIDE_STEP   = 3'd3;
   localparam logic [2:0] CSR_PADDING       = 3'd4;
   localparam logic [2:0] CSR_OUTPUT_WIDTH  = 3'd5;
   localparam logic [2:0] CSR_OUTPUT_HEIGHT = 3'd6;
   localparam logic [2:0] CSR_COLUMN_ROWS   = 3'd7;

   typedef struct packed {
      logic [6:0]  input_width;
      logic [6:0]  input_height;
      logic [3:0]  kernel_size;
      logic [3:0]  stride_step;
      logic [2:0]  padding;
      logic [6:0]  output_width;
      logic [6:0]  output_height;
      logic [11:0] column_rows;
   } cfg_type;

   typedef struct packed {
      logic        operation;
      logic [11:0] pixel_address;
      logic [31:0] pixel_value;
      logic [11:0] matrix_row;
      logic [5:0]  out_y;
      logic [5:0]  out_x;
   } req_type;

   // One store access per cycle, in request order.
   typedef struct packed {
      logic             valid;
      logic             write;
      logic             lookup;
      logic [IDX_W-1:0] index;
      logic [31:0]      wdata;
      logic [23:0]      position;
      logic             is_padding;
      logic             status;
   } acc_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] element_value;
      logic [23:0] element_position;
      logic        is_padding;
      logic        status;
   } rsp_type;

   // floor(2^16 / k): quotient estimate is exact or one low for 12-bit dividends.
   function automatic logic [16:0] recip(input logic [3:0] k);
      logic [16:0] r;
      case (k)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21845;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13107;
         4'd6:    r = 17'd10922;
         4'd7:    r = 17'd9362;
         4'd8:    r = 17'd8192;
         4'd9:    r = 17'd7281;
         4'd10:   r = 17'd6553;
         4'd11:   r = 17'd5957;
         4'd12:   r = 17'd5461;
         4'd13:   r = 17'd5041;
         4'd14:   r = 17'd4681;
         4'd15:   r = 17'd4369;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/imcol_addr_gen.sv */
// Address pipeline: splits the matrix row, forms the source pixel and store index.
`timescale 1ns / 1ps
`default_nettype none

module imcol_addr_gen (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   take,
   input  imcol_pkg::req_type    req,
   input  imcol_pkg::cfg_type    cfg,
   output imcol_pkg::acc_type    acc
);

   typedef struct packed {
      logic        valid;
      logic        write;
      logic [11:0] addr;
      logic [31:0] wdata;
      logic [11:0] row;
      logic [5:0]  oy;
      logic [5:0]  ox;
      logic        err;
      logic [27:0] prod;
      logic [18:0] rowoh;
      logic [3:0]  kx;
      logic [11:0] q;
      logic [23:0] pos;
      logic [9:0]  oys;
      logic [9:0]  oxs;
      logic [3:0]  ky;
      logic [11:0] chan;
      logic [9:0]  col;
      logic        col_out;
      logic [9:0]  rowv;
      logic        pad;
      logic [18:0] chmul;
      logic [19:0] t;
   } stg_type;

   localparam int NSTG = 7;

   stg_type st_ff [NSTG];
   stg_type st_in [NSTG];
   imcol_pkg::acc_type acc_ff, acc_in;

   logic [16:0] rcp;
   logic [28:0] prod_a, prod_c;
   logic [18:0] rowoh_a;
   logic [11:0] qe_b, cqe_d;
   logic [15:0] qk_b, rem_b, ck_d, rem_d;
   logic [18:0] possum_b;
   logic [25:0] posm_b;
   logic [9:0]  csum_d, rsum_e;
   logic [27:0] idxm_g;

   assign rcp = imcol_pkg::recip(cfg.kernel_size);

   // A: capture the request
   always_comb begin
      st_in[0] = '0;
      st_in[0].valid = take;
      st_in[0].write = (req.operation == imcol_pkg::OP_WRITE);
      st_in[0].addr  = req.pixel_address;
      st_in[0].wdata = req.pixel_value;
      st_in[0].row   = req.matrix_row;
      st_in[0].oy    = req.out_y;
      st_in[0].ox    = req.out_x;
   end

   // B: range check, row * reciprocal, row * output_height
   always_comb begin
      st_in[1] = st_ff[0];
      st_in[1].err = (cfg.kernel_size == 4'd0) || (st_ff[0].row >= cfg.column_rows) ||
                     ({1'b0, st_ff[0].oy} >= cfg.output_height) ||
                     ({1'b0, st_ff[0].ox} >= cfg.output_width);
      prod_a  = {17'b0, st_ff[0].row} * {12'b0, rcp};
      rowoh_a = {7'b0, st_ff[0].row} * {12'b0, cfg.output_height};
      st_in[1].prod  = prod_a[27:0];
      st_in[1].rowoh = rowoh_a;
   end

   // C: first quotient correction gives kx; finish the linear position
   always_comb begin
      st_in[2] = st_ff[1];
      qe_b  = st_ff[1].prod[27:16];
      qk_b  = {4'b0, qe_b} * {12'b0, cfg.kernel_size};
      rem_b = {4'b0, st_ff[1].row} - qk_b;
      if (rem_b[4:0] >= {1'b0, cfg.kernel_size}) begin
         st_in[2].kx = 4'(rem_b[4:0] - {1'b0, cfg.kernel_size});
         st_in[2].q  = qe_b + 12'd1;
      end else begin
         st_in[2].kx = rem_b[3:0];
         st_in[2].q  = qe_b;
      end
      possum_b = st_ff[1].rowoh + {13'b0, st_ff[1].oy};
      posm_b   = {7'b0, possum_b} * {19'b0, cfg.output_width};
      st_in[2].pos = posm_b[23:0] + {18'b0, st_ff[1].ox};
   end

   // D: quotient * reciprocal, output offsets times stride
   always_comb begin
      st_in[3] = st_ff[2];
      prod_c = {17'b0, st_ff[2].q} * {12'b0, rcp};
      st_in[3].prod = prod_c[27:0];
      st_in[3].oys  = {4'b0, st_ff[2].oy} * {6'b0, cfg.stride_step};
      st_in[3].oxs  = {4'b0, st_ff[2].ox} * {6'b0, cfg.stride_step};
   end

   // E: second correction gives ky and channel; source column bounds
   always_comb begin
      st_in[4] = st_ff[3];
      cqe_d = st_ff[3].prod[27:16];
      ck_d  = {4'b0, cqe_d} * {12'b0, cfg.kernel_size};
      rem_d = {4'b0, st_ff[3].q} - ck_d;
      if (rem_d[4:0] >= {1'b0, cfg.kernel_size}) begin
         st_in[4].ky   = 4'(rem_d[4:0] - {1'b0, cfg.kernel_size});
         st_in[4].chan = cqe_d + 12'd1;
      end else begin
         st_in[4].ky   = rem_d[3:0];
         st_in[4].chan = cqe_d;
      end
      csum_d = {6'b0, st_ff[3].kx} + st_ff[3].oxs;
      st_in[4].col     = csum_d - {7'b0, cfg.padding};
      st_in[4].col_out = (csum_d < {7'b0, cfg.padding}) ||
                         ((csum_d - {7'b0, cfg.padding}) >= {3'b0, cfg.input_width});
   end

   // F: source row bounds, channel plane base
   always_comb begin
      st_in[5] = st_ff[4];
      rsum_e = {6'b0, st_ff[4].ky} + st_ff[4].oys;
      st_in[5].rowv  = rsum_e - {7'b0, cfg.padding};
      st_in[5].pad   = st_ff[4].col_out || (rsum_e < {7'b0, cfg.padding}) ||
                       ((rsum_e - {7'b0, cfg.padding}) >= {3'b0, cfg.input_height});
      st_in[5].chmul = {12'b0, cfg.input_height} * {7'b0, st_ff[4].chan};
   end

   // G: row within the whole store
   always_comb begin
      st_in[6] = st_ff[5];
      st_in[6].t = {1'b0, st_ff[5].chmul} + {10'b0, st_ff[5].rowv};
   end

   // store access beat
   always_comb begin
      idxm_g = {21'b0, cfg.input_width} * {8'b0, st_ff[6].t};
      acc_in.valid      = st_ff[6].valid;
      acc_in.write      = st_ff[6].write;
      acc_in.lookup     = !st_ff[6].write && !st_ff[6].err && !st_ff[6].pad;
      acc_in.index      = st_ff[6].write ? {16'b0, st_ff[6].addr}
                                         : idxm_g + {18'b0, st_ff[6].col};
      acc_in.wdata      = st_ff[6].wdata;
      acc_in.position   = st_ff[6].err ? 24'd0 : st_ff[6].pos;
      acc_in.is_padding = !st_ff[6].err && st_ff[6].pad;
      acc_in.status     = st_ff[6].err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) begin
            st_ff[i] <= '0;
         end
         acc_ff <= '0;
      end else begin
         st_ff  <= st_in;
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

   a_kx_in_range : assert property (@(posedge clock) disable iff (reset)
      (st_ff[2].valid && !st_ff[2].write && !st_ff[2].err) |->
         (st_ff[2].kx < cfg.kernel_size))
      else $error("kernel x offset not below kernel size");

   a_ky_in_range : assert property (@(posedge clock) disable iff (reset)
      (st_ff[4].valid && !st_ff[4].write && !st_ff[4].err) |->
         (st_ff[4].ky < cfg.kernel_size))
      else $error("kernel y offset not below kernel size");

endmodule

`default_nettype wire

/* hdl/imcol_store.sv */
// Image word store with registered read and the result stage.
`timescale 1ns / 1ps
`default_nettype none

module imcol_store #(
   parameter int IMAGE_WORDS = imcol_pkg::IMAGE_WORDS_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  imcol_pkg::acc_type    acc,
   output imcol_pkg::rsp_type    rsp
);

   localparam int AW = $clog2(IMAGE_WORDS);

   logic [31:0] mem [IMAGE_WORDS];
   logic [31:0] rdata_ff;
   logic        in_range;
   logic        valid_ff, valid_in;
   logic        use_mem_ff, use_mem_in;
   logic [23:0] pos_ff, pos_in;
   logic        pad_ff, pad_in;
   logic        status_ff, status_in;

   assign in_range = acc.index < imcol_pkg::IDX_W'(IMAGE_WORDS);

   // Accesses arrive in request order, one per cycle, so a read always
   // sees every earlier write without forwarding.
   always_ff @(posedge clock) begin
      if (acc.valid && acc.write && in_range) begin
         mem[acc.index[AW-1:0]] <= acc.wdata;
      end
      rdata_ff <= mem[acc.index[AW-1:0]];
   end

   always_comb begin
      valid_in   = acc.valid && !acc.write;
      use_mem_in = acc.lookup && in_range;
      pos_in     = (acc.lookup && !in_range) ? 24'd0 : acc.position;
      pad_in     = acc.is_padding;
      status_in  = acc.status || (acc.lookup && !in_range);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      use_mem_ff <= use_mem_in;
      pos_ff     <= pos_in;
      pad_ff     <= pad_in;
      status_ff  <= status_in;
   end

   always_comb begin
      rsp.valid            = valid_ff;
      rsp.element_value    = use_mem_ff ? rdata_ff : 32'd0;
      rsp.element_position = pos_ff;
      rsp.is_padding       = pad_ff;
      rsp.status           = status_ff;
   end

   a_read_gives_result : assert property (@(posedge clock) disable iff (reset)
      (acc.valid && !acc.write) |=> rsp.valid)
      else $error("store read beat produced no result");

   a_error_is_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status) |->
         (rsp.element_value == 32'd0 && rsp.element_position == 24'd0 && !rsp.is_padding))
      else $error("error result carries data");

endmodule

`default_nettype wire

/* hdl/image_to_column_gather.sv */
// Top level of the im2col gather: register file, address pipeline and store.
//
// Usage:
//   Configuration: csr_write_enable, csr_index, csr_write_data write one size
//   register per cycle; write only while no request is in flight.
//   Requests: a beat is taken when start is high and busy is low. Operation
//   0 writes req_pixel_value to req_pixel_address; operation 1 reads one
//   column-matrix element (req_matrix_row, req_out_y, req_out_x).
//   Results: each read beat yields one result, marked by rsp_valid for one
//   cycle; writes yield none. Each beat passes through the address stages,
//   the access register and the store's result register; results leave in request order.
//   Throughput: one beat per cycle, reads and writes mixed freely; busy is
//   only high during reset. The rate is set by the single store port, which
//   serves exactly one access per cycle at the end of the pipeline.
//   The receiver cannot stall; results must be taken as they appear.
//   Reset: size registers return to 1 (padding to 0) and all in-flight
//   beats are dropped. The image store is not cleared; read only words
//   that were written.
`timescale 1ns / 1ps
`default_nettype none

module image_to_column_gather #(
   parameter int IMAGE_WORDS = imcol_pkg::IMAGE_WORDS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire         req_operation,
   input  wire  [11:0] req_pixel_address,
   input  wire  [31:0] req_pixel_value,
   input  wire  [11:0] req_matrix_row,
   input  wire  [5:0]  req_out_y,
   input  wire  [5:0]  req_out_x,
   output logic        rsp_valid,
   output logic [31:0] rsp_element_value,
   output logic [23:0] rsp_element_position,
   output logic        rsp_is_padding,
   output logic        rsp_status,
   input  wire         csr_write_enable,
   input  wire  [2:0]  csr_index,
   input  wire  [11:0] csr_write_data
);

   imcol_pkg::cfg_type cfg_ff, cfg_in;
   imcol_pkg::req_type req;
   imcol_pkg::acc_type acc;
   imcol_pkg::rsp_type rsp;
   logic               take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            imcol_pkg::CSR_INPUT_WIDTH:   cfg_in.input_width   = csr_write_data[6:0];
            imcol_pkg::CSR_INPUT_HEIGHT:  cfg_in.input_height  = csr_write_data[6:0];
            imcol_pkg::CSR_KERNEL_SIZE:   cfg_in.kernel_size   = csr_write_data[3:0];
            imcol_pkg::CSR_STRIDE_STEP:   cfg_in.stride_step   = csr_write_data[3:0];
            imcol_pkg::CSR_PADDING:       cfg_in.padding       = csr_write_data[2:0];
            imcol_pkg::CSR_OUTPUT_WIDTH:  cfg_in.output_width  = csr_write_data[6:0];
            imcol_pkg::CSR_OUTPUT_HEIGHT: cfg_in.output_height = csr_write_data[6:0];
            imcol_pkg::CSR_COLUMN_ROWS:   cfg_in.column_rows   = csr_write_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_width   <= 7'd1;
         cfg_ff.input_height  <= 7'd1;
         cfg_ff.kernel_size   <= 4'd1;
         cfg_ff.stride_step   <= 4'd1;
         cfg_ff.padding       <= 3'd0;
         cfg_ff.output_width  <= 7'd1;
         cfg_ff.output_height <= 7'd1;
         cfg_ff.column_rows   <= 12'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign busy = reset;
   assign take = start && !busy;

   always_comb begin
      req.operation     = req_operation;
      req.pixel_address = req_pixel_address;
      req.pixel_value   = req_pixel_value;
      req.matrix_row    = req_matrix_row;
      req.out_y         = req_out_y;
      req.out_x         = req_out_x;
   end

   imcol_addr_gen u_addr_gen (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req),
      .cfg   (cfg_ff),
      .acc   (acc)
   );

   imcol_store #(
      .IMAGE_WORDS (IMAGE_WORDS)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .acc   (acc),
      .rsp   (rsp)
   );

   assign rsp_valid            = rsp.valid;
   assign rsp_element_value    = rsp.element_value;
   assign rsp_element_position = rsp.element_position;
   assign rsp_is_padding       = rsp.is_padding;
   assign rsp_status           = rsp.status;

   // strobe is registered through the address stages, the access beat and the result stage
   a_read_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |->
         ##9 (rsp_valid == ($past(req_operation, 9) == imcol_pkg::OP_READ)))
      else $error("result strobe does not match beat nine cycles earlier");

endmodule

`default_nettype wire
